// ===== rtl/julian_day_date_converter_macros.svh =====
// Assertion macros for the Julian day converter
`ifndef JULIAN_DAY_DATE_CONVERTER_MACROS_SVH
`define JULIAN_DAY_DATE_CONVERTER_MACROS_SVH

`ifndef ASSERT_OFF
`define JDDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define JDDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JDDC_ASSERT_IMP(lbl, ante, cons, msg)
`define JDDC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/jddc_pkg.sv =====
package jddc_pkg;

  localparam int NSTAGE = 6;
  localparam int TDATA_W = 48;

  // date to day number
  localparam int GREG_DATE = 588829;
  localparam int DIV100_SH = 20;
  localparam logic [13:0] DIV100_K = 14'd10486;

  // day number to date
  localparam logic [22:0] GREG_JDN = 23'd2299161;
  localparam logic [24:0] ALPHA_OFS = 25'd7468865;
  localparam longint ALPHA_DIV = 146097;
  localparam int ALPHA_SH = 43;
  localparam logic [25:0] ALPHA_K = 26'(((longint'(1) << ALPHA_SH) + ALPHA_DIV - 1) / ALPHA_DIV);
  localparam logic [27:0] YC_OFS = 28'd2442;
  localparam longint YC_DIV = 7305;
  localparam int YC_SH = 41;
  localparam logic [28:0] YC_K = 29'(((longint'(1) << YC_SH) + YC_DIV - 1) / YC_DIV);

  typedef struct packed {
    logic [NSTAGE-1:0] en;
  } pipe_ctl_t;

  // floor(30.6001 * (m + 1)) for adjusted months
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] t;
    case (m)
      4'd3:    t = 9'd122;
      4'd4:    t = 9'd153;
      4'd5:    t = 9'd183;
      4'd6:    t = 9'd214;
      4'd7:    t = 9'd244;
      4'd8:    t = 9'd275;
      4'd9:    t = 9'd306;
      4'd10:   t = 9'd336;
      4'd11:   t = 9'd367;
      4'd12:   t = 9'd397;
      4'd13:   t = 9'd428;
      4'd14:   t = 9'd459;
      4'd15:   t = 9'd489;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // ceil(30.601 * k)
  function automatic logic [9:0] month_thr(input logic [4:0] k);
    logic [9:0] t;
    case (k)
      5'd1:    t = 10'd31;
      5'd2:    t = 10'd62;
      5'd3:    t = 10'd92;
      5'd4:    t = 10'd123;
      5'd5:    t = 10'd154;
      5'd6:    t = 10'd184;
      5'd7:    t = 10'd215;
      5'd8:    t = 10'd245;
      5'd9:    t = 10'd276;
      5'd10:   t = 10'd307;
      5'd11:   t = 10'd337;
      5'd12:   t = 10'd368;
      5'd13:   t = 10'd398;
      5'd14:   t = 10'd429;
      5'd15:   t = 10'd460;
      5'd16:   t = 10'd490;
      default: t = 10'd1023;
    endcase
    return t;
  endfunction

  // floor(30.601 * e)
  function automatic logic [8:0] month_floor(input logic [4:0] e);
    logic [8:0] t;
    case (e)
      5'd1:    t = 9'd30;
      5'd2:    t = 9'd61;
      5'd3:    t = 9'd91;
      5'd4:    t = 9'd122;
      5'd5:    t = 9'd153;
      5'd6:    t = 9'd183;
      5'd7:    t = 9'd214;
      5'd8:    t = 9'd244;
      5'd9:    t = 9'd275;
      5'd10:   t = 9'd306;
      5'd11:   t = 9'd336;
      5'd12:   t = 9'd367;
      5'd13:   t = 9'd397;
      5'd14:   t = 9'd428;
      5'd15:   t = 9'd459;
      5'd16:   t = 9'd489;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // largest e with 30.601 * e <= rem
  function automatic logic [4:0] month_index(input logic [9:0] rem);
    logic [4:0] e;
    e = 5'd0;
    for (int k = 1; k <= 16; k++) begin
      if (rem >= month_thr(5'(k))) begin
        e = 5'(k);
      end
    end
    return e;
  endfunction

endpackage

// ===== rtl/jddc_to_jdn.sv =====
module jddc_to_jdn (
  input  logic               clk,
  input  jddc_pkg::pipe_ctl_t ctl,
  input  logic signed [14:0] year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  output logic [22:0]        jdn
);

  logic signed [24:0] key;
  logic signed [15:0] y_ext;
  logic signed [15:0] y_adj;
  logic [3:0]         m_adj;

  logic signed [15:0] s1_y;
  logic [3:0]         s1_m;
  logic [4:0]         s1_d;
  logic               s1_greg;
  logic [14:0]        s1_abs;
  logic               s1_neg;

  logic signed [27:0] t_ext;
  logic signed [27:0] t_prod;
  logic signed [27:0] t_div;

  logic [28:0]        s2_prod;
  logic signed [24:0] s2_a;
  logic [8:0]         s2_b;
  logic [4:0]         s2_d;
  logic               s2_greg;
  logic               s2_neg;

  logic [8:0]         q;
  logic signed [8:0]  s3_c;
  logic signed [24:0] s3_sum;
  logic               s3_greg;

  logic signed [8:0]  c_rnd;
  logic signed [8:0]  c_q;
  logic signed [9:0]  n;
  logic signed [24:0] r;

  logic [22:0]        s4_jdn;
  logic [22:0]        s5_jdn;
  logic [22:0]        s6_jdn;

  always_comb begin
    key = $signed({{10{year[14]}}, year}) * 25'sd372
        + $signed({21'd0, month}) * 25'sd31
        + $signed({20'd0, day});
    y_ext = {year[14], year};
    y_adj = (month <= 4'd2) ? y_ext - 16'sd1 : y_ext;
    m_adj = (month <= 4'd2) ? month + 4'd12 : month;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_y    <= y_adj;
      s1_m    <= m_adj;
      s1_d    <= day;
      s1_greg <= key >= 25'(jddc_pkg::GREG_DATE);
      s1_abs  <= y_adj[15] ? 15'(-y_adj) : y_adj[14:0];
      s1_neg  <= y_adj[15];
    end
  end

  always_comb begin
    t_ext  = {{12{s1_y[15]}}, s1_y} + 28'sd4716;
    t_prod = t_ext * 28'sd1461;
    t_div  = (t_prod + (t_prod[27] ? 28'sd3 : 28'sd0)) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_prod <= {14'd0, s1_abs} * {15'd0, jddc_pkg::DIV100_K};
      s2_a    <= t_div[24:0];
      s2_b    <= jddc_pkg::month_term(s1_m);
      s2_d    <= s1_d;
      s2_greg <= s1_greg;
      s2_neg  <= s1_neg;
    end
  end

  assign q = s2_prod[jddc_pkg::DIV100_SH +: 9];

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_c    <= s2_neg ? -$signed(q) : $signed(q);
      s3_sum  <= s2_a + $signed({16'd0, s2_b}) + $signed({20'd0, s2_d}) - 25'sd1524;
      s3_greg <= s2_greg;
    end
  end

  always_comb begin
    c_rnd = s3_c + (s3_c[8] ? 9'sd3 : 9'sd0);
    c_q   = c_rnd >>> 2;
    n     = s3_greg ? 10'sd2 - {s3_c[8], s3_c} + {c_q[8], c_q} : 10'sd0;
    r     = s3_sum + {{15{n[9]}}, n};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_jdn <= r[22:0];
    end
    if (ctl.en[4]) begin
      s5_jdn <= s4_jdn;
    end
    if (ctl.en[5]) begin
      s6_jdn <= s5_jdn;
    end
  end

  assign jdn = s6_jdn;

endmodule

// ===== rtl/jddc_to_date.sv =====
module jddc_to_date (
  input  logic                clk,
  input  jddc_pkg::pipe_ctl_t ctl,
  input  logic [22:0]         day_number,
  output logic [14:0]         yr,
  output logic [3:0]          mo,
  output logic [4:0]          dy
);

  logic [22:0] s1_z;
  logic        s1_greg;
  logic [24:0] s1_x;

  logic [50:0] s2_p;
  logic [22:0] s2_z;
  logic        s2_greg;

  logic [7:0]  alpha;
  logic [23:0] a;
  logic [23:0] s3_b;

  logic [27:0] s4_x;
  logic [23:0] s4_b;

  logic [56:0] s5_p;
  logic [23:0] s5_b;

  logic [14:0] yc;
  logic [25:0] yc_days;
  logic [23:0] rem_full;
  logic [14:0] s6_yc;
  logic [9:0]  s6_rem;

  logic [4:0]  e;
  logic [9:0]  dd_full;

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_z    <= day_number;
      s1_greg <= day_number >= jddc_pkg::GREG_JDN;
      s1_x    <= {day_number, 2'b00} - jddc_pkg::ALPHA_OFS;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_p    <= {26'd0, s1_x} * {25'd0, jddc_pkg::ALPHA_K};
      s2_z    <= s1_z;
      s2_greg <= s1_greg;
    end
  end

  always_comb begin
    alpha = s2_p[jddc_pkg::ALPHA_SH +: 8];
    a = s2_greg ? {1'b0, s2_z} + 24'd1 + {16'd0, alpha} - {18'd0, alpha[7:2]}
                : {1'b0, s2_z};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_b <= a + 24'd1524;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_x <= {4'd0, s3_b} * 28'd20 - jddc_pkg::YC_OFS;
      s4_b <= s3_b;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s5_p <= {29'd0, s4_x} * {28'd0, jddc_pkg::YC_K};
      s5_b <= s4_b;
    end
  end

  always_comb begin
    yc       = s5_p[jddc_pkg::YC_SH +: 15];
    yc_days  = {11'd0, yc} * 26'd1461;
    rem_full = s5_b - yc_days[25:2];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s6_yc  <= yc;
      s6_rem <= rem_full[9:0];
    end
  end

  always_comb begin
    e       = jddc_pkg::month_index(s6_rem);
    dd_full = s6_rem - {1'b0, jddc_pkg::month_floor(e)};
    dy      = dd_full[4:0];
    if (e > 5'd13) begin
      mo = 4'(e - 5'd13);
      yr = s6_yc - 15'd4715;
    end else begin
      mo = 4'(e - 5'd1);
      yr = s6_yc - 15'd4716;
    end
  end

endmodule

// ===== rtl/julian_day_date_converter.sv =====
// Throughput: one item per cycle unless stalled; six work stages and an output register,
// each stage holding while the one after it is full and stalled.
// Reset (rst, synchronous, active high) clears the stage valid bits and
// m_tvalid; data registers are not reset.
`include "julian_day_date_converter_macros.svh"

module julian_day_date_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // year[14:0], month[18:15], day[23:19], day_number[46:24], zero pad[47]
  input  logic [jddc_pkg::TDATA_W-1:0] s_tdata,
  // op[0]
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // out_year[14:0], out_month[18:15], out_day[23:19], out_day_number[46:24], zero pad[47]
  output logic [jddc_pkg::TDATA_W-1:0] m_tdata
);

  jddc_pkg::pipe_ctl_t         ctl;
  logic                        en_out;
  logic [jddc_pkg::NSTAGE-1:0] v;
  logic [jddc_pkg::NSTAGE-1:0] op;
  logic                        op_out;

  logic [22:0] jdn;
  logic [14:0] yr;
  logic [3:0]  mo;
  logic [4:0]  dy;

  always_comb begin
    en_out = !m_tvalid || m_tready;
    ctl.en[jddc_pkg::NSTAGE-1] = !v[jddc_pkg::NSTAGE-1] || en_out;
    for (int k = jddc_pkg::NSTAGE - 2; k >= 0; k--) begin
      ctl.en[k] = !v[k] || ctl.en[k+1];
    end
  end

  assign s_tready = ctl.en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.en[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < jddc_pkg::NSTAGE; k++) begin
        if (ctl.en[k]) begin
          v[k] <= v[k-1];
        end
      end
      if (en_out) begin
        m_tvalid <= v[jddc_pkg::NSTAGE-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      op[0] <= s_tuser;
    end
    for (int k = 1; k < jddc_pkg::NSTAGE; k++) begin
      if (ctl.en[k]) begin
        op[k] <= op[k-1];
      end
    end
  end

  jddc_to_jdn u_to_jdn (
    .clk   (clk),
    .ctl   (ctl),
    .year  (s_tdata[14:0]),
    .month (s_tdata[18:15]),
    .day   (s_tdata[23:19]),
    .jdn   (jdn)
  );

  jddc_to_date u_to_date (
    .clk        (clk),
    .ctl        (ctl),
    .day_number (s_tdata[46:24]),
    .yr         (yr),
    .mo         (mo),
    .dy         (dy)
  );

  always_ff @(posedge clk) begin
    if (en_out) begin
      op_out <= op[jddc_pkg::NSTAGE-1];
      if (op[jddc_pkg::NSTAGE-1]) begin
        m_tdata <= {1'b0, 23'd0, dy, mo, yr};
      end else begin
        m_tdata <= {1'b0, jdn, 5'd0, 4'd0, 15'd0};
      end
    end
  end

  `JDDC_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty output")
  `JDDC_ASSERT_NXT(a_accept_fills, s_tvalid && s_tready, v[0], "accepted item lost at entry")
  `JDDC_ASSERT_IMP(a_unused_zero, m_tvalid, m_tdata[46:24] == 23'd0 || m_tdata[23:0] == 24'd0, "both result groups set")
  `JDDC_ASSERT_IMP(a_date_range, m_tvalid && op_out, m_tdata[18:15] >= 4'd1 && m_tdata[18:15] <= 4'd12 && m_tdata[23:19] != 5'd0, "date result out of range")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  localparam int TDATA_W = jddc_pkg::TDATA_W;

  localparam logic OP_TO_DAY = 1'b0;
  localparam logic OP_TO_DATE = 1'b1;
  localparam int LATENCY = 7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS = 200;
  localparam int STALL_LIMIT = 2000;
  localparam longint GREG_DATE_KEY = 588829;
  localparam longint GREG_DAY_NUMBER = 2299161;
  localparam longint MAX_DAY_NUMBER = 5373484;

  typedef struct packed {
    logic               op;
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [22:0]        day_number;
  } cal_req_t;

  typedef struct packed {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [22:0]        day_number;
  } cal_res_t;

  typedef struct {
    logic     drain_first;
    cal_req_t req;
  } queued_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // year[14:0], month[18:15], day[23:19], day_number[46:24], zero pad[47]
  logic [TDATA_W-1:0] s_tdata = '0;
  // op[0]
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // out_year[14:0], out_month[18:15], out_day[23:19], out_day_number[46:24], zero pad[47]
  logic [TDATA_W-1:0] m_tdata;

  queued_req_t requests[$];
  cal_res_t    expected_dates[$];
  queued_req_t next_req;
  cal_req_t    bus_req;
  cal_res_t    bus_res;
  cal_res_t    want;
  logic        item_taken = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          items_sent = 0;
  int          total_items = 0;
  int          errors = 0;

  julian_day_date_converter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  assign bus_req = {s_tuser, s_tdata[14:0], s_tdata[18:15], s_tdata[23:19], s_tdata[46:24]};
  assign bus_res = {m_tdata[14:0], m_tdata[18:15], m_tdata[23:19], m_tdata[46:24]};

  function automatic cal_res_t convert_calendar(input cal_req_t rq);
    cal_res_t res;
    logic     greg;
    longint   y, m, d, cent, corr, jd;
    longint   a, alpha, b, yc, rem, e, dd;
    res = '0;
    if (rq.op == OP_TO_DAY) begin
      y = longint'($signed(rq.year));
      m = rq.month;
      d = rq.day;
      corr = 0;
      greg = (y * 372 + m * 31 + d) >= GREG_DATE_KEY;
      if (m <= 2) begin
        m = m + 12;
        y = y - 1;
      end
      if (greg) begin
        cent = y / 100;
        corr = 2 - cent + cent / 4;
      end
      jd = (1461 * (y + 4716)) / 4 + (306001 * (m + 1)) / 10000 + d + corr - 1524;
      res.day_number = jd[22:0];
    end else begin
      a = rq.day_number;
      if (a >= GREG_DAY_NUMBER) begin
        alpha = (4 * a - 7468865) / 146097;
        a = a + 1 + alpha - alpha / 4;
      end
      b = a + 1524;
      yc = (20 * b - 2442) / 7305;
      rem = b - (1461 * yc) / 4;
      e = (1000 * rem) / 30601;
      dd = rem - (30601 * e) / 1000;
      if (e > 13) begin
        res.month = 4'(e - 13);
        res.year = 15'(yc - 4715);
      end else begin
        res.month = 4'(e - 1);
        res.year = 15'(yc - 4716);
      end
      res.day = 5'(dd);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input longint got, input longint exp_val);
    if (got != exp_val) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
    end
  endtask

  task automatic add_date(input int y, input int m, input int d, input logic drain);
    queued_req_t q;
    q.drain_first = drain;
    q.req = '0;
    q.req.op = OP_TO_DAY;
    q.req.year = 15'(y);
    q.req.month = 4'(m);
    q.req.day = 5'(d);
    requests.push_back(q);
  endtask

  task automatic add_day_number(input int z);
    queued_req_t q;
    q.drain_first = 1'b0;
    q.req = '0;
    q.req.op = OP_TO_DATE;
    q.req.day_number = 23'(z);
    requests.push_back(q);
  endtask

  function automatic cal_req_t random_req();
    cal_req_t rq;
    int       pick;
    int       yr;
    pick = $urandom_range(0, 99);
    rq = cal_req_t'(48'({$urandom(), $urandom()}));
    if (pick < 40) begin
      rq.op = OP_TO_DAY;
      if ($urandom_range(0, 4) == 0) begin
        yr = $urandom_range(1580, 1584);
      end else begin
        yr = int'($urandom_range(0, 14711)) - 4712;
      end
      rq.year = 15'(yr);
      rq.month = 4'($urandom_range(1, 12));
      rq.day = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(29, 31)) : 5'($urandom_range(1, 28));
    end else if (pick < 75) begin
      rq.op = OP_TO_DATE;
      if ($urandom_range(0, 4) == 0) begin
        rq.day_number = 23'(GREG_DAY_NUMBER - 400 + $urandom_range(0, 800));
      end else begin
        rq.day_number = 23'($urandom_range(0, MAX_DAY_NUMBER));
      end
    end
    return rq;
  endfunction

  // sender: hold an item until taken, then advance after an optional gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !item_taken) begin
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      s_tvalid <= 1'b0;
    end else if (requests.size() == 0 ||
                 (requests[0].drain_first && expected_dates.size() != 0)) begin
      s_tvalid <= 1'b0;
    end else begin
      next_req = requests.pop_front();
      s_tdata <= TDATA_W'({next_req.req.day_number, next_req.req.day,
                           next_req.req.month, next_req.req.year});
      s_tuser <= next_req.req.op;
      s_tvalid <= 1'b1;
      if (requests.size() > QUIET_ITEMS && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 16);
      end
    end
  end

  // receiver: stall in bursts, none in the tail of the run
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (requests.size() > QUIET_ITEMS && $urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(convert_calendar(bus_req));
        items_sent++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = expected_dates.pop_front();
          check_field("out_year", longint'($signed(bus_res.year)), longint'($signed(want.year)));
          check_field("out_month", bus_res.month, want.month);
          check_field("out_day", bus_res.day, want.day);
          check_field("out_day_number", bus_res.day_number, want.day_number);
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    queued_req_t q;
    add_date(1582, 10, 15, 1'b0);
    add_date(1582, 10, 14, 1'b0);
    add_date(1582, 10, 4, 1'b0);
    add_date(-4712, 1, 1, 1'b0);
    add_date(9999, 12, 31, 1'b0);
    add_date(2000, 1, 1, 1'b0);
    add_date(1900, 2, 29, 1'b0);
    add_date(0, 3, 1, 1'b0);
    add_date(2024, 0, 10, 1'b0);
    add_date(2024, 15, 10, 1'b0);
    add_date(2024, 13, 0, 1'b0);
    add_date(1600, 2, 31, 1'b0);
    add_date(-16384, 1, 1, 1'b0);
    add_date(16383, 12, 31, 1'b0);
    add_day_number(0);
    add_day_number(2299160);
    add_day_number(2299161);
    add_day_number(2451545);
    add_day_number(1721424);
    add_day_number(5373484);
    add_day_number(5373485);
    add_day_number(8388607);
    add_date(2100, 3, 1, 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      q.drain_first = (i == RANDOM_ITEMS / 2);
      q.req = random_req();
      requests.push_back(q);
    end
    total_items = requests.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (items_sent < total_items) @(negedge clk);
    for (int k = 0; k < 600 && expected_dates.size() != 0; k++) @(negedge clk);
    repeat (4 * LATENCY) @(negedge clk);
    if (expected_dates.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_dates.size()));
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
